FILE: hw/rtl/ttb_pkg.sv
// Types and constants shared by the two-theta intensity binning block.
`timescale 1ns / 1ps

package ttb_pkg;

   localparam int SUM_W       = 48;
   localparam int COUNT_W     = 24;
   localparam int ANGLE_W     = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int DIV_NUM_W   = 56;
   localparam int DIV_DEN_W   = 24;
   localparam int DIV_STEP_W  = 6;
   localparam int WEIGHT_W    = 19;

   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [DIV_STEP_W-1:0] BIN_STEPS = 6'd24;
   localparam logic [DIV_STEP_W-1:0] AVG_STEPS = 6'd56;

   localparam logic [32:0] ROUND_HALF = 33'd8192;

   localparam logic [1:0] OP_ACCUM      = 2'd0;
   localparam logic [1:0] OP_READ       = 2'd1;
   localparam logic [1:0] OP_READ_CLEAR = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_MIN_TWO_THETA   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BIN_WIDTH       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BINS_IN_USE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_AVERAGE_MODE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INTENSITY_SCALE = 3'd4;

   localparam logic [23:0] RST_MIN_TWO_THETA   = 24'd0;
   localparam logic [23:0] RST_BIN_WIDTH       = 24'd65536;
   localparam logic [10:0] RST_BINS_IN_USE     = 11'd1024;
   localparam logic        RST_AVERAGE_MODE    = 1'b0;
   localparam logic [15:0] RST_INTENSITY_SCALE = 16'd256;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] intensity;
      logic        intensity_is_nan;
      logic [15:0] correction;
      logic        correction_is_nan;
      logic        use_correction;
      logic [23:0] two_theta;
      logic [9:0]  bin_select;
   } req_type;

   typedef struct packed {
      logic        skipped;
      logic [9:0]  bin_hit;
      logic        clamped;
      logic [47:0] bin_value;
      logic [23:0] bin_count;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
   } div_ctl_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WEIGHT,
      ST_DIV_BIN,
      ST_READ,
      ST_MODIFY,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV_AVG,
      ST_DONE
   } state_type;

endpackage

FILE: hw/rtl/ttb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ttb_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ttb_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ttb_div (
   input  logic                            clock,
   input  logic                            reset,
   input  ttb_pkg::div_ctl_type            ctl,
   input  logic [ttb_pkg::DIV_NUM_W-1:0]   dividend,
   input  logic [ttb_pkg::DIV_DEN_W-1:0]   divisor,
   output logic                            done,
   output logic [ttb_pkg::DIV_NUM_W-1:0]   quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [ttb_pkg::DIV_STEP_W-1:0]    cnt_ff, cnt_in;
   logic [ttb_pkg::DIV_NUM_W-1:0]     num_ff, num_in;
   logic [ttb_pkg::DIV_NUM_W-1:0]     quo_ff, quo_in;
   logic [ttb_pkg::DIV_DEN_W-1:0]     rem_ff, rem_in;
   logic [ttb_pkg::DIV_DEN_W-1:0]     den_ff, den_in;
   logic [ttb_pkg::DIV_DEN_W:0]       trial;
   logic [ttb_pkg::DIV_DEN_W:0]       diff;
   logic                              ge;

   always_comb begin
      trial   = {rem_ff, num_ff[ttb_pkg::DIV_NUM_W-1]};
      ge      = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctl.steps;
         num_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[ttb_pkg::DIV_DEN_W-1:0] : trial[ttb_pkg::DIV_DEN_W-1:0];
         quo_in = {quo_ff[ttb_pkg::DIV_NUM_W-2:0], ge};
         num_in = {num_ff[ttb_pkg::DIV_NUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ttb_pkg::DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/two_theta_intensity_binning.sv
// Top level of the two-theta intensity binning block.
`timescale 1ns / 1ps

// Weighted histogram over detector pixels in two-theta bins, with a per-bin
// sum and count held in one RAM of NUM_BINS words. One word is handled at a
// time; req_ready is high only while the sequencer is idle. After reset a
// clearing pass writes every bin to zero, one bin a cycle, and no word is
// taken during it. An accumulate waits on the 24-step bin index division in
// the shared divider; one below the first bin edge skips the division, and
// one dropped for a NaN flag goes straight to the result. A read in average
// mode with a non-empty bin makes two passes through the shared 24x16
// multiplier and a 56-step division by the bin count. The result register
// lets the next word in while a result waits.
module two_theta_intensity_binning #(
   parameter int NUM_BINS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ttb_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ttb_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [ttb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ttb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int                 IDX_W      = $clog2(NUM_BINS);
   localparam int                 ENTRY_W    = ttb_pkg::SUM_W + ttb_pkg::COUNT_W;
   localparam logic [23:0]        NUM_BINS_W = 24'(NUM_BINS);
   localparam logic [IDX_W-1:0]   LAST_BIN   = IDX_W'(NUM_BINS - 1);

   ttb_pkg::state_type               state_ff, state_in;
   ttb_pkg::req_type                 req_ff, req_in;
   ttb_pkg::rsp_type                 rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]                 clr_ff, clr_in;
   logic [IDX_W-1:0]                 bin_ff, bin_in;
   logic [9:0]                       hit_ff, hit_in;
   logic                             skip_ff, skip_in;
   logic                             clamped_ff, clamped_in;
   logic [ttb_pkg::SUM_W-1:0]        value_ff, value_in;
   logic [ttb_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [ttb_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [63:0]                      acc_ff, acc_in;

   logic [23:0]                      min_ff;
   logic [23:0]                      width_ff;
   logic [10:0]                      biu_ff;
   logic                             avg_ff;
   logic [15:0]                      scale_ff;

   logic [23:0]                      width_eff;
   logic [23:0]                      n_eff;
   logic [23:0]                      angle_diff;
   logic                             under;
   logic [23:0]                      mul_a;
   logic [15:0]                      mul_b;
   logic [39:0]                      prod;
   logic [32:0]                      rnd;
   logic [ttb_pkg::WEIGHT_W-1:0]     weight;
   logic [ttb_pkg::SUM_W:0]          sum_add;
   logic [ttb_pkg::SUM_W-1:0]        rd_sum;
   logic [ttb_pkg::COUNT_W-1:0]      rd_cnt;
   logic [ttb_pkg::SUM_W-1:0]        new_sum;
   logic [ttb_pkg::COUNT_W-1:0]      new_cnt;
   logic [23:0]                      bin_q;

   ttb_pkg::div_ctl_type             div_ctl;
   logic [ttb_pkg::DIV_NUM_W-1:0]    div_num;
   logic [ttb_pkg::DIV_DEN_W-1:0]    div_den;
   logic                             div_done;
   logic [ttb_pkg::DIV_NUM_W-1:0]    div_quo;

   logic                             ram_wr_en;
   logic [IDX_W-1:0]                 ram_wr_addr;
   logic [ENTRY_W-1:0]               ram_wr_data;
   logic                             ram_rd_en;
   logic [ENTRY_W-1:0]               ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= ttb_pkg::RST_MIN_TWO_THETA;
         width_ff <= ttb_pkg::RST_BIN_WIDTH;
         biu_ff   <= ttb_pkg::RST_BINS_IN_USE;
         avg_ff   <= ttb_pkg::RST_AVERAGE_MODE;
         scale_ff <= ttb_pkg::RST_INTENSITY_SCALE;
      end else if (csr_we) begin
         unique case (csr_index)
            ttb_pkg::REG_MIN_TWO_THETA:   min_ff   <= csr_wdata;
            ttb_pkg::REG_BIN_WIDTH:       width_ff <= csr_wdata;
            ttb_pkg::REG_BINS_IN_USE:     biu_ff   <= csr_wdata[10:0];
            ttb_pkg::REG_AVERAGE_MODE:    avg_ff   <= csr_wdata[0];
            ttb_pkg::REG_INTENSITY_SCALE: scale_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   ttb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   ttb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_BINS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (bin_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      width_eff  = (width_ff == 24'd0) ? 24'd1 : width_ff;
      if (biu_ff == 11'd0) begin
         n_eff = 24'd1;
      end else if (24'(biu_ff) > NUM_BINS_W) begin
         n_eff = NUM_BINS_W;
      end else begin
         n_eff = 24'(biu_ff);
      end
      under      = req_ff.two_theta < min_ff;
      angle_diff = req_ff.two_theta - min_ff;

      unique case (state_ff)
         ttb_pkg::ST_WEIGHT: begin
            mul_a = 24'(req_ff.intensity);
            mul_b = req_ff.correction;
         end
         ttb_pkg::ST_MUL_LO: begin
            mul_a = sum_ff[23:0];
            mul_b = scale_ff;
         end
         default: begin
            mul_a = sum_ff[47:24];
            mul_b = scale_ff;
         end
      endcase
      prod = 40'(mul_a) * 40'(mul_b);

      rd_sum  = ram_rd_data[ENTRY_W-1:ttb_pkg::COUNT_W];
      rd_cnt  = ram_rd_data[ttb_pkg::COUNT_W-1:0];
      rnd     = 33'(acc_ff[31:0]) + ttb_pkg::ROUND_HALF;
      weight  = req_ff.use_correction ? rnd[32:14] : ttb_pkg::WEIGHT_W'(req_ff.intensity);
      sum_add = (ttb_pkg::SUM_W+1)'(rd_sum) + (ttb_pkg::SUM_W+1)'(weight);
      new_sum = sum_add[ttb_pkg::SUM_W] ? ttb_pkg::SUM_MAX : sum_add[ttb_pkg::SUM_W-1:0];
      new_cnt = (rd_cnt == ttb_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
      bin_q   = div_quo[23:0];
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      clr_in       = clr_ff;
      bin_in       = bin_ff;
      hit_in       = hit_ff;
      skip_in      = skip_ff;
      clamped_in   = clamped_ff;
      value_in     = value_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      req_ready    = 1'b0;
      div_ctl      = '0;
      div_num      = {angle_diff, 32'd0};
      div_den      = width_eff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = bin_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         ttb_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST_BIN) begin
               state_in = ttb_pkg::ST_IDLE;
            end
         end
         ttb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in     = req_data;
               hit_in     = '0;
               skip_in    = 1'b0;
               clamped_in = 1'b0;
               value_in   = '0;
               count_in   = '0;
               unique case (req_data.op)
                  ttb_pkg::OP_ACCUM: begin
                     if (req_data.intensity_is_nan ||
                         (req_data.use_correction && req_data.correction_is_nan)) begin
                        skip_in  = 1'b1;
                        state_in = ttb_pkg::ST_DONE;
                     end else begin
                        state_in = ttb_pkg::ST_WEIGHT;
                     end
                  end
                  ttb_pkg::OP_READ, ttb_pkg::OP_READ_CLEAR: begin
                     hit_in = req_data.bin_select;
                     bin_in = IDX_W'(req_data.bin_select);
                     if (24'(req_data.bin_select) >= NUM_BINS_W) begin
                        state_in = ttb_pkg::ST_DONE;
                     end else begin
                        state_in = ttb_pkg::ST_READ;
                     end
                  end
                  default: state_in = ttb_pkg::ST_DONE;
               endcase
            end
         end
         ttb_pkg::ST_WEIGHT: begin
            acc_in = 64'(prod);
            if (under) begin
               bin_in     = '0;
               clamped_in = 1'b1;
               state_in   = ttb_pkg::ST_READ;
            end else begin
               div_ctl.start = 1'b1;
               div_ctl.steps = ttb_pkg::BIN_STEPS;
               state_in      = ttb_pkg::ST_DIV_BIN;
            end
         end
         ttb_pkg::ST_DIV_BIN: begin
            if (div_done) begin
               if (bin_q >= n_eff) begin
                  bin_in     = IDX_W'(n_eff - 24'd1);
                  clamped_in = 1'b1;
               end else begin
                  bin_in = bin_q[IDX_W-1:0];
               end
               state_in = ttb_pkg::ST_READ;
            end
         end
         ttb_pkg::ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ttb_pkg::ST_MODIFY;
         end
         ttb_pkg::ST_MODIFY: begin
            if (req_ff.op == ttb_pkg::OP_ACCUM) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {new_sum, new_cnt};
               hit_in      = 10'(bin_ff);
               count_in    = new_cnt;
               state_in    = ttb_pkg::ST_DONE;
            end else begin
               sum_in   = rd_sum;
               count_in = rd_cnt;
               value_in = rd_sum;
               if (req_ff.op == ttb_pkg::OP_READ_CLEAR) begin
                  ram_wr_en = 1'b1;
               end
               if (avg_ff && rd_cnt != '0) begin
                  state_in = ttb_pkg::ST_MUL_LO;
               end else begin
                  state_in = ttb_pkg::ST_DONE;
               end
            end
         end
         ttb_pkg::ST_MUL_LO: begin
            acc_in   = 64'(prod);
            state_in = ttb_pkg::ST_MUL_HI;
         end
         ttb_pkg::ST_MUL_HI: begin
            acc_in        = acc_ff + (64'(prod) << 24);
            div_ctl.start = 1'b1;
            div_ctl.steps = ttb_pkg::AVG_STEPS;
            div_num       = acc_in[63:8];
            div_den       = count_ff;
            state_in      = ttb_pkg::ST_DIV_AVG;
         end
         ttb_pkg::ST_DIV_AVG: begin
            div_num = acc_ff[63:8];
            div_den = count_ff;
            if (div_done) begin
               value_in = (div_quo[ttb_pkg::DIV_NUM_W-1:ttb_pkg::SUM_W] != '0)
                        ? ttb_pkg::SUM_MAX : div_quo[ttb_pkg::SUM_W-1:0];
               state_in = ttb_pkg::ST_DONE;
            end
         end
         ttb_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.skipped   = skip_ff;
               rsp_in.bin_hit   = hit_ff;
               rsp_in.clamped   = clamped_ff;
               rsp_in.bin_value = value_ff;
               rsp_in.bin_count = count_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ttb_pkg::ST_IDLE;
            end
         end
         default: state_in = ttb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttb_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      bin_ff     <= bin_in;
      hit_ff     <= hit_in;
      skip_ff    <= skip_in;
      clamped_ff <= clamped_in;
      value_ff   <= value_in;
      sum_ff     <= sum_in;
      count_ff   <= count_in;
      acc_ff     <= acc_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the two-theta intensity binning block.
`timescale 1ns / 1ps

module testbench;
   import ttb_pkg::*;

   localparam int NUM_BINS = 1024;
   localparam int WORDS_PER_PHASE = 100;
   localparam int RANDOM_PHASES = 8;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      req_type                   word;
      bit                        typed;
      rsp_type                   want;
      logic [CSR_INDEX_W-1:0]    reg_index;
      logic [CSR_DATA_W-1:0]     reg_value;
   } row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [SUM_W-1:0]   sum_mirror [NUM_BINS];
   logic [COUNT_W-1:0] count_mirror [NUM_BINS];
   logic [23:0]        mirror_min = RST_MIN_TWO_THETA;
   logic [23:0]        mirror_width = RST_BIN_WIDTH;
   logic [10:0]        mirror_bins = RST_BINS_IN_USE;
   logic               mirror_avg = RST_AVERAGE_MODE;
   logic [15:0]        mirror_scale = RST_INTENSITY_SCALE;

   rsp_type awaited_results [$];
   row_type directed_rows [$];
   rsp_type oldest_result;

   bit quiet = 1'b0;
   int unsigned stall_left = 0;
   int error_count = 0;
   int results_seen = 0;
   int pixels_binned = 0;
   int pixels_clamped = 0;
   int pixels_flagged = 0;
   int bins_read = 0;
   int bins_cleared = 0;
   int averaged_reads = 0;
   int register_writes = 0;

   two_theta_intensity_binning #(.NUM_BINS(NUM_BINS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      for (int i = 0; i < NUM_BINS; i++) begin
         sum_mirror[i] = '0;
         count_mirror[i] = '0;
      end
   end

   function automatic logic [31:0] active_bins();
      if (mirror_bins == 0) return 1;
      if (mirror_bins > NUM_BINS) return NUM_BINS;
      return 32'(mirror_bins);
   endfunction

   function automatic logic [31:0] bin_divisor();
      return (mirror_width == 0) ? 32'd1 : 32'(mirror_width);
   endfunction

   function automatic rsp_type predict_bin_result(input req_type w);
      rsp_type     r;
      logic [63:0] weight;
      logic [63:0] product;
      logic [63:0] average;
      logic [31:0] quot;
      logic [31:0] idx;
      r = '0;
      case (w.op)
         OP_ACCUM: begin
            if (w.intensity_is_nan || (w.use_correction && w.correction_is_nan)) begin
               r.skipped = 1'b1;
            end else begin
               if (w.use_correction)
                  weight = (64'(w.intensity) * 64'(w.correction) + 64'd8192) >> 14;
               else
                  weight = 64'(w.intensity);
               if (w.two_theta < mirror_min) begin
                  idx = 0;
                  r.clamped = 1'b1;
               end else begin
                  quot = (32'(w.two_theta) - 32'(mirror_min)) / bin_divisor();
                  if (quot >= active_bins()) begin
                     idx = active_bins() - 1;
                     r.clamped = 1'b1;
                  end else begin
                     idx = quot;
                  end
               end
               if (sum_mirror[idx] > SUM_MAX - weight[SUM_W-1:0])
                  sum_mirror[idx] = SUM_MAX;
               else
                  sum_mirror[idx] = sum_mirror[idx] + weight[SUM_W-1:0];
               if (count_mirror[idx] != COUNT_MAX)
                  count_mirror[idx] = count_mirror[idx] + 1'b1;
               r.bin_hit = idx[9:0];
               r.bin_count = count_mirror[idx];
            end
         end
         OP_READ, OP_READ_CLEAR: begin
            r.bin_hit = w.bin_select;
            r.bin_count = count_mirror[w.bin_select];
            if (!mirror_avg || count_mirror[w.bin_select] == 0) begin
               r.bin_value = sum_mirror[w.bin_select];
            end else begin
               product = 64'(sum_mirror[w.bin_select]) * 64'(mirror_scale);
               average = product / (64'(count_mirror[w.bin_select]) * 64'd256);
               r.bin_value = (average > 64'(SUM_MAX)) ? SUM_MAX : average[SUM_W-1:0];
            end
            if (w.op == OP_READ_CLEAR) begin
               sum_mirror[w.bin_select] = '0;
               count_mirror[w.bin_select] = '0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type pixel(input logic [15:0] intensity, input logic intensity_nan,
                                     input logic [15:0] correction, input logic correction_nan,
                                     input logic use_corr, input logic [23:0] angle);
      req_type w;
      w = '0;
      w.op = OP_ACCUM;
      w.intensity = intensity;
      w.intensity_is_nan = intensity_nan;
      w.correction = correction;
      w.correction_is_nan = correction_nan;
      w.use_correction = use_corr;
      w.two_theta = angle;
      return w;
   endfunction

   function automatic req_type lookup(input logic [1:0] op, input logic [9:0] sel);
      req_type w;
      w = '0;
      w.op = op;
      w.bin_select = sel;
      return w;
   endfunction

   function automatic row_type word_row(input req_type w);
      row_type row;
      row = '{kind: ROW_WORD, word: w, typed: 1'b0, want: '0, reg_index: '0, reg_value: '0};
      return row;
   endfunction

   function automatic row_type typed_row(input req_type w, input rsp_type want);
      row_type row;
      row = '{kind: ROW_WORD, word: w, typed: 1'b1, want: want, reg_index: '0, reg_value: '0};
      return row;
   endfunction

   function automatic row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] value);
      row_type row;
      row = '{kind: ROW_CSR, word: '0, typed: 1'b0, want: '0, reg_index: idx, reg_value: value};
      return row;
   endfunction

   function automatic req_type random_word();
      req_type     w;
      logic [63:0] angle;
      logic [31:0] divisor;
      logic [31:0] offset;
      int unsigned roll;
      divisor = bin_divisor();
      roll = $urandom_range(0, 99);
      if (roll < 60) w.op = OP_ACCUM;
      else if (roll < 80) w.op = OP_READ;
      else if (roll < 95) w.op = OP_READ_CLEAR;
      else w.op = OP_UNUSED;
      case ($urandom_range(0, 5))
         0: w.intensity = '0;
         1: w.intensity = '1;
         default: w.intensity = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: w.correction = '0;
         1: w.correction = '1;
         2: w.correction = 16'h4000;
         default: w.correction = 16'($urandom);
      endcase
      w.intensity_is_nan = ($urandom_range(0, 11) == 0);
      w.correction_is_nan = ($urandom_range(0, 11) == 0);
      w.use_correction = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
         case ($urandom_range(0, 3))
            0: offset = 0;
            1: offset = divisor - 1;
            default: offset = $urandom_range(0, divisor - 1);
         endcase
         angle = 64'(mirror_min) + 64'($urandom_range(0, active_bins() + 1)) * 64'(divisor)
                 + 64'(offset);
         if (angle > 64'hFF_FFFF) angle = 64'($urandom_range(0, 24'hFF_FFFF));
      end else if (roll < 8 && mirror_min != 0) begin
         angle = 64'($urandom_range(0, mirror_min - 1));
      end else begin
         angle = 64'($urandom_range(0, 24'hFF_FFFF));
      end
      w.two_theta = angle[23:0];
      if ($urandom_range(0, 3) != 0)
         w.bin_select = 10'($urandom_range(0, active_bins() - 1));
      else
         w.bin_select = 10'($urandom);
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] ERROR %s", $realtime, msg);
      error_count++;
   endtask

   task automatic compare_field(input string field, input logic [47:0] got,
                                input logic [47:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d: %s is %0h, predicted %0h",
                                   results_seen, field, got, want));
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_MIN_TWO_THETA:   mirror_min = value;
         REG_BIN_WIDTH:       mirror_width = value;
         REG_BINS_IN_USE:     mirror_bins = value[10:0];
         REG_AVERAGE_MODE:    mirror_avg = value[0];
         REG_INTENSITY_SCALE: mirror_scale = value[15:0];
         default: ;
      endcase
      register_writes++;
   endtask

   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type predicted;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      predicted = predict_bin_result(w);
      awaited_results.push_back(typed ? want : predicted);
      case (w.op)
         OP_ACCUM: begin
            if (predicted.skipped) begin
               pixels_flagged++;
            end else begin
               pixels_binned++;
               if (predicted.clamped) pixels_clamped++;
            end
         end
         OP_READ, OP_READ_CLEAR: begin
            bins_read++;
            if (w.op == OP_READ_CLEAR) bins_cleared++;
            if (mirror_avg && predicted.bin_count != 0) averaged_reads++;
         end
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // check results in order and stall the result side in bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none outstanding", results_seen));
         end else begin
            oldest_result = awaited_results.pop_front();
            compare_field("skipped", 48'(rsp_data.skipped), 48'(oldest_result.skipped));
            compare_field("bin_hit", 48'(rsp_data.bin_hit), 48'(oldest_result.bin_hit));
            compare_field("clamped", 48'(rsp_data.clamped), 48'(oldest_result.clamped));
            compare_field("bin_value", rsp_data.bin_value, oldest_result.bin_value);
            compare_field("bin_count", 48'(rsp_data.bin_count), 48'(oldest_result.bin_count));
         end
         results_seen++;
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #6_000_000;
      $display("Simulation limit reached with %0d results outstanding", awaited_results.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [23:0] cfg_value;
      directed_rows.push_back(typed_row(lookup(OP_READ, 10'd0), rsp_type'{1'b0, 10'd0, 1'b0, 48'd0, 24'd0}));
      directed_rows.push_back(typed_row(lookup(OP_READ, 10'd1023),
                                        rsp_type'{1'b0, 10'd1023, 1'b0, 48'd0, 24'd0}));
      directed_rows.push_back(typed_row(pixel(16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 1'b1, 24'hFF_FFFF),
                                        rsp_type'{1'b1, 10'd0, 1'b0, 48'd0, 24'd0}));
      directed_rows.push_back(typed_row(pixel(16'h1234, 1'b0, 16'h4000, 1'b1, 1'b1, 24'h0),
                                        rsp_type'{1'b1, 10'd0, 1'b0, 48'd0, 24'd0}));
      directed_rows.push_back(typed_row(pixel(16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 1'b0, 24'h0),
                                        rsp_type'{1'b0, 10'd0, 1'b0, 48'd0, 24'd1}));
      directed_rows.push_back(word_row(pixel(16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 1'b1, 24'hFF_FFFF)));
      directed_rows.push_back(word_row(pixel(16'd1, 1'b0, 16'h2000, 1'b0, 1'b1, 24'h01_0000)));
      directed_rows.push_back(word_row(pixel(16'd3, 1'b0, 16'h1FFF, 1'b0, 1'b1, 24'h01_FFFF)));
      directed_rows.push_back(word_row(pixel(16'd0, 1'b0, 16'd0, 1'b0, 1'b1, 24'h00_FFFF)));
      directed_rows.push_back(typed_row(req_type'{OP_UNUSED, 16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 1'b1,
                                                  24'hFF_FFFF, 10'h3FF}, '0));
      directed_rows.push_back(word_row(lookup(OP_READ, 10'd0)));
      directed_rows.push_back(word_row(lookup(OP_READ_CLEAR, 10'd1)));
      directed_rows.push_back(typed_row(lookup(OP_READ, 10'd1), rsp_type'{1'b0, 10'd1, 1'b0, 48'd0, 24'd0}));
      directed_rows.push_back(csr_row(REG_MIN_TWO_THETA, 24'h10_0000));
      directed_rows.push_back(csr_row(REG_BIN_WIDTH, 24'd0));
      directed_rows.push_back(csr_row(REG_BINS_IN_USE, 24'd0));
      directed_rows.push_back(word_row(pixel(16'd100, 1'b0, 16'd0, 1'b0, 1'b0, 24'h0)));
      directed_rows.push_back(word_row(pixel(16'd200, 1'b0, 16'd0, 1'b0, 1'b0, 24'h10_0000)));
      directed_rows.push_back(word_row(pixel(16'd300, 1'b0, 16'd0, 1'b0, 1'b0, 24'h10_0001)));
      directed_rows.push_back(csr_row(REG_MIN_TWO_THETA, 24'd0));
      directed_rows.push_back(csr_row(REG_BIN_WIDTH, 24'd1));
      directed_rows.push_back(csr_row(REG_BINS_IN_USE, 24'd2047));
      directed_rows.push_back(word_row(pixel(16'hFFFF, 1'b0, 16'd0, 1'b0, 1'b0, 24'hFF_FFFF)));
      directed_rows.push_back(word_row(pixel(16'd7, 1'b0, 16'd0, 1'b0, 1'b0, 24'd1023)));
      directed_rows.push_back(csr_row(REG_BIN_WIDTH, 24'hFF_FFFF));
      directed_rows.push_back(csr_row(REG_BINS_IN_USE, 24'd1024));
      directed_rows.push_back(csr_row(REG_AVERAGE_MODE, 24'd1));
      directed_rows.push_back(csr_row(REG_INTENSITY_SCALE, 24'hFFFF));
      directed_rows.push_back(word_row(pixel(16'd5, 1'b0, 16'd0, 1'b0, 1'b0, 24'hFF_FFFF)));
      directed_rows.push_back(word_row(lookup(OP_READ, 10'd0)));
      directed_rows.push_back(typed_row(lookup(OP_READ, 10'd2), rsp_type'{1'b0, 10'd2, 1'b0, 48'd0, 24'd0}));
      directed_rows.push_back(csr_row(REG_INTENSITY_SCALE, 24'd1));
      directed_rows.push_back(word_row(lookup(OP_READ_CLEAR, 10'd1023)));
      directed_rows.push_back(word_row(lookup(OP_READ, 10'd0)));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_drained();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         if (phase == RANDOM_PHASES - 1) quiet = 1'b1;
         case ($urandom_range(0, 3))
            0: cfg_value = 24'd0;
            1: cfg_value = 24'hFF_FFFF;
            2: cfg_value = 24'($urandom_range(0, 24'h01_0000));
            default: cfg_value = 24'($urandom);
         endcase
         write_reg(REG_MIN_TWO_THETA, cfg_value);
         case ($urandom_range(0, 5))
            0: cfg_value = 24'd0;
            1: cfg_value = 24'd1;
            2: cfg_value = 24'hFF_FFFF;
            3: cfg_value = 24'($urandom_range(1, 64));
            4: cfg_value = 24'($urandom_range(1, 24'h01_0000));
            default: cfg_value = 24'($urandom);
         endcase
         write_reg(REG_BIN_WIDTH, cfg_value);
         case ($urandom_range(0, 6))
            0: cfg_value = 24'd0;
            1: cfg_value = 24'd1;
            2: cfg_value = 24'd1024;
            3: cfg_value = 24'd2047;
            4: cfg_value = 24'($urandom_range(1, 16));
            5: cfg_value = 24'($urandom_range(1025, 2047));
            default: cfg_value = 24'($urandom_range(1, 1024));
         endcase
         write_reg(REG_BINS_IN_USE, cfg_value);
         write_reg(REG_AVERAGE_MODE, 24'(phase % 2));
         case ($urandom_range(0, 3))
            0: cfg_value = 24'd1;
            1: cfg_value = 24'hFFFF;
            2: cfg_value = 24'd256;
            default: cfg_value = 24'($urandom_range(1, 16'hFFFF));
         endcase
         write_reg(REG_INTENSITY_SCALE, cfg_value);
         for (int n = 0; n < WORDS_PER_PHASE; n++) send_word(random_word(), 1'b0, '0);
      end

      wait_drained();
      repeat (80) @(posedge clock);
      $display("Binned %0d pixels (%0d clamped into range), dropped %0d flagged pixels",
               pixels_binned, pixels_clamped, pixels_flagged);
      $display("Read %0d bins (%0d as averages, %0d cleared) across %0d register writes",
               bins_read, averaged_reads, bins_cleared, register_writes);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
